// ===== sv/prcc_pkg.sv =====
// Package for the palette RAM color converter.
// Holds the types, constants and color packing functions shared by the controller, datapath and top level.
// No dependencies.
package prcc_pkg;

  localparam int unsigned STORE_DEPTH  = 8192;
  localparam int unsigned ADDR_W       = 13;
  localparam int unsigned ENTRY_W      = 17;
  localparam int unsigned BANK_ENTRIES = 4096;
  localparam logic [ADDR_W-1:0] BANK_OFS = ADDR_W'(BANK_ENTRIES % STORE_DEPTH);

  localparam logic       ACT_WRITE = 1'b1;
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SECOND = 2'b10
  } state_t;

  typedef struct packed {
    logic first;
    logic second;
  } cmd_t;

  typedef struct packed {
    logic is_word;
    logic is_read;
    logic held_read;
  } sts_t;

  // {dark, RGBA5551}
  function automatic logic [ENTRY_W-1:0] enc_color(input logic [15:0] v,
                                                   input logic [ADDR_W-1:0] idx);
    logic [15:0] c;
    c = {v[11:8], v[14], v[7:4], v[13], v[3:0], v[12], (idx[3:0] != 4'd0)};
    return {v[15], c};
  endfunction

  function automatic logic [15:0] dec_color(input logic [ENTRY_W-1:0] e);
    return {e[16], e[11], e[6], e[1], e[15:12], e[10:7], e[5:2]};
  endfunction

endpackage

// ===== sv/prcc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module prcc_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/prcc_ctrl.sv =====
// Controller for the palette RAM color converter: accept, word sequencing, result strobe.
// Depends on prcc_pkg.
module prcc_ctrl
  import prcc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign busy   = (state_r == ST_SECOND);
  assign accept = start && !busy;

  always_comb begin
    cmd.first  = accept;
    cmd.second = (state_r == ST_SECOND);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (sts.is_word) begin
            state_nxt = ST_SECOND;
          end else begin
            out_valid_nxt = sts.is_read;
          end
        end
      end
      ST_SECOND: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = sts.held_read;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_second_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SECOND |=> state_r == ST_IDLE)
    else $error("second access lasted more than one cycle");

  a_word_goes_second: assert property (@(posedge clk) disable iff (!rst_n)
    accept && sts.is_word |=> state_r == ST_SECOND)
    else $error("word item did not issue its second access");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_SECOND) || $past(accept && sts.is_read))
    else $error("result strobe without a read");

endmodule

// ===== sv/prcc_dp.sv =====
// Datapath for the palette RAM color converter: item registers, bank, addressing,
// color packing and unpacking, palette RAM. Depends on prcc_pkg and prcc_ram.
module prcc_dp
  import prcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_write_en,
  input  logic              cfg_palette_bank,
  input  logic              in_action,
  input  logic [12:0]       in_byte_address,
  input  logic [1:0]        in_access_size,
  input  logic [31:0]       in_write_data,
  output logic [31:0]       out_read_data
);

  logic               bank_r;
  logic               action_r;
  logic               word_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [15:0]        lo_r;
  logic [ENTRY_W-1:0] hi_r;

  logic [15:0]        half0;
  logic [ADDR_W-1:0]  byte_addr;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  ofs;
  logic [15:0]        wr_half;
  logic               ram_en;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (cfg_write_en) begin
      bank_r <= cfg_palette_bank;
    end
  end

  always_comb begin
    priority if (in_access_size == SIZE_WORD) begin
      half0 = in_write_data[31:16];
    end else if (in_access_size == SIZE_BYTE) begin
      half0 = {in_write_data[7:0], in_write_data[7:0]};
    end else begin
      half0 = in_write_data[15:0];
    end
  end

  always_comb begin
    byte_addr = cmd.second ? ADDR_W'(addr_r + ADDR_W'(2)) : in_byte_address;
    ofs       = bank_r ? BANK_OFS : '0;
    idx       = ADDR_W'({1'b0, byte_addr[ADDR_W-1:1]} + ofs);
    wr_half   = cmd.second ? lo_r : half0;
    ram_en    = cmd.first || cmd.second;
    ram_we    = cmd.second ? (action_r == ACT_WRITE) : (in_action == ACT_WRITE);
    ram_wdata = enc_color(wr_half, idx);
  end

  always_ff @(posedge clk) begin
    if (cmd.first) begin
      action_r <= in_action;
      word_r   <= (in_access_size == SIZE_WORD);
      addr_r   <= in_byte_address;
      lo_r     <= in_write_data[15:0];
    end
    if (cmd.second) begin
      hi_r <= ram_rdata;
    end
  end

  prcc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (idx),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.is_word   = (in_access_size == SIZE_WORD);
    sts.is_read   = (in_action != ACT_WRITE);
    sts.held_read = (action_r != ACT_WRITE);
  end

  assign out_read_data = word_r ? {dec_color(hi_r), dec_color(ram_rdata)}
                                : {16'd0, dec_color(ram_rdata)};

endmodule

// ===== sv/palette_ram_color_converter_top.sv =====
// A byte or halfword read strobes its result in the cycle after accept, a word read
// after its second access. Byte and halfword items go 1 per cycle while busy is low;
// a word item holds busy high for its second access on the single palette RAM port.
// Reset clears the controller and the bank register; palette contents are not cleared.
// Results come as a one-cycle strobe; the receiver cannot stall.
module palette_ram_color_converter_top
  import prcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic        cfg_palette_bank,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [12:0] in_byte_address,
  input  logic [1:0]  in_access_size,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  output logic [31:0] out_read_data
);

  cmd_t cmd;
  sts_t sts;

  prcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  prcc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_write_en     (cfg_write_en),
    .cfg_palette_bank (cfg_palette_bank),
    .in_action        (in_action),
    .in_byte_address  (in_byte_address),
    .in_access_size   (in_access_size),
    .in_write_data    (in_write_data),
    .out_read_data    (out_read_data)
  );

endmodule

// ===== verif/palette_ram_color_converter_top_tb.sv =====
// Self-checking testbench for palette_ram_color_converter_top: directed and random
// reads and writes in both banks, checked against a behavioral palette model.
// Depends on prcc_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module palette_ram_color_converter_top_tb;
  import prcc_pkg::*;

  localparam logic       ACT_READ    = 1'b0;
  localparam logic [1:0] SIZE_HALF   = 2'd1;
  localparam logic [1:0] SIZE_CODE3  = 2'd3;
  localparam int         SETTLE      = 4;
  localparam int         CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic        cfg_palette_bank = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = 1'b0;
  logic [12:0] in_byte_address = '0;
  logic [1:0]  in_access_size = '0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic [31:0] out_read_data;

  logic [15:0] pal_rgba [STORE_DEPTH];
  logic        pal_dark [STORE_DEPTH];
  bit          pal_written [STORE_DEPTH];
  logic        bank_sel = 1'b0;
  logic [31:0] read_words_due [$];
  logic [31:0] read_word_now;
  int          error_count = 0;
  int          cycle_count = 0;
  int          dense_left = 0;

  palette_ram_color_converter_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_palette_bank(cfg_palette_bank),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_byte_address(in_byte_address),
    .in_access_size(in_access_size),
    .in_write_data(in_write_data),
    .out_valid(out_valid),
    .out_read_data(out_read_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("palette_ram_color_converter_top_tb: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (read_words_due.size() == 0) begin
        report_mismatch("read data with no read pending", out_read_data, 'x);
      end else begin
        read_word_now = read_words_due.pop_front();
        if (out_read_data !== read_word_now)
          report_mismatch("read_data", out_read_data, read_word_now);
      end
    end
  end

  function automatic logic [12:0] entry_of(input logic [12:0] addr);
    return {1'b0, addr[12:1]} + (bank_sel ? BANK_OFS : 13'd0);
  endfunction

  function automatic void store_color(input logic [12:0] addr, input logic [15:0] v);
    logic [12:0] idx;
    idx = entry_of(addr);
    pal_rgba[idx] = {v[11:8], v[14], v[7:4], v[13], v[3:0], v[12], idx[3:0] != 4'd0};
    pal_dark[idx] = v[15];
    pal_written[idx] = 1'b1;
  endfunction

  function automatic logic [15:0] load_color(input logic [12:0] addr);
    logic [12:0] idx;
    logic [15:0] c;
    idx = entry_of(addr);
    c = pal_rgba[idx];
    return {pal_dark[idx], c[11], c[6], c[1], c[15:12], c[10:7], c[5:2]};
  endfunction

  function automatic bit readable(input logic [12:0] addr, input logic [1:0] size);
    return pal_written[entry_of(addr)] &&
           (size != SIZE_WORD || pal_written[entry_of(addr + 13'd2)]);
  endfunction

  function automatic void palette_apply(input logic act, input logic [12:0] addr,
                                        input logic [1:0] size, input logic [31:0] data);
    logic [12:0] addr2;
    addr2 = addr + 13'd2;
    if (act == ACT_WRITE) begin
      if (size == SIZE_WORD) begin
        store_color(addr, data[31:16]);
        store_color(addr2, data[15:0]);
      end else if (size == SIZE_BYTE) begin
        store_color(addr, {2{data[7:0]}});
      end else begin
        store_color(addr, data[15:0]);
      end
    end else if (size == SIZE_WORD) begin
      read_words_due.push_back({load_color(addr), load_color(addr2)});
    end else begin
      read_words_due.push_back({16'h0000, load_color(addr)});
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (dense_left > 0) begin
      dense_left--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) dense_left = $urandom_range(10, 40);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic act, input logic [12:0] addr,
                           input logic [1:0] size, input logic [31:0] data);
    int gap;
    start <= 1'b1;
    in_action <= act;
    in_byte_address <= addr;
    in_access_size <= size;
    in_write_data <= data;
    do @(posedge clk); while (busy !== 1'b0);
    palette_apply(act, addr, size, data);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (read_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_bank(input logic b);
    drain();
    cfg_write_en <= 1'b1;
    cfg_palette_bank <= b;
    @(posedge clk);
    bank_sel = b;
    cfg_write_en <= 1'b0;
  endtask

  task automatic test_field_extremes();
    send_item(ACT_WRITE, 13'h0000, SIZE_HALF, 32'h0000_0000);
    send_item(ACT_READ, 13'h0000, SIZE_HALF, 32'h0);
    send_item(ACT_WRITE, 13'h0000, SIZE_HALF, 32'hFFFF_FFFF);
    send_item(ACT_READ, 13'h0001, SIZE_BYTE, 32'hFFFF_FFFF);
    send_item(ACT_WRITE, 13'h1FFE, SIZE_WORD, 32'h8421_7BDE);
    send_item(ACT_READ, 13'h1FFE, SIZE_WORD, 32'h0);
    send_item(ACT_READ, 13'h0000, SIZE_HALF, 32'h0);
    send_item(ACT_WRITE, 13'h1FFF, SIZE_BYTE, 32'hFFFF_FFA5);
    send_item(ACT_READ, 13'h1FFE, SIZE_CODE3, 32'h0);
    send_item(ACT_WRITE, 13'h0020, SIZE_CODE3, 32'h0000_8000);
    send_item(ACT_WRITE, 13'h001E, SIZE_HALF, 32'h0000_7FFF);
    send_item(ACT_READ, 13'h001E, SIZE_WORD, 32'h0);
    send_item(ACT_WRITE, 13'h0003, SIZE_WORD, 32'h1234_5678);
    send_item(ACT_READ, 13'h0002, SIZE_WORD, 32'h0);
    send_item(ACT_READ, 13'h0005, SIZE_BYTE, 32'h0);
    send_item(ACT_WRITE, 13'h1000, SIZE_WORD, 32'hFFFF_FFFF);
    send_item(ACT_READ, 13'h1001, SIZE_WORD, 32'h0);
    send_item(ACT_WRITE, 13'h0FFE, SIZE_BYTE, 32'hFFFF_FF00);
    send_item(ACT_READ, 13'h0FFE, SIZE_HALF, 32'hFFFF_FFFF);
  endtask

  task automatic test_bank_select();
    set_bank(1'b1);
    send_item(ACT_WRITE, 13'h0000, SIZE_HALF, 32'h0000_0F0F);
    send_item(ACT_READ, 13'h0000, SIZE_HALF, 32'h0);
    send_item(ACT_WRITE, 13'h1FFE, SIZE_WORD, 32'hC3A5_5A3C);
    send_item(ACT_READ, 13'h1FFE, SIZE_WORD, 32'h0);
    set_bank(1'b0);
    send_item(ACT_READ, 13'h0000, SIZE_HALF, 32'h0);
  endtask

  task automatic test_random_traffic(input int count, input logic [12:0] hot_base);
    logic        act;
    logic [12:0] addr;
    logic [1:0]  size;
    int          r;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      if ($urandom_range(0, 9) < 7) addr = hot_base + 13'($urandom_range(0, 63));
      else addr = 13'($urandom_range(0, 8191));
      r = $urandom_range(0, 7);
      if (r < 2) size = SIZE_BYTE;
      else if (r < 4) size = SIZE_HALF;
      else if (r < 7) size = SIZE_WORD;
      else size = SIZE_CODE3;
      act = ($urandom_range(0, 99) < 55) ? ACT_READ : ACT_WRITE;
      if (act == ACT_READ && !readable(addr, size)) act = ACT_WRITE;
      send_item(act, addr, size, $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_bank(1'b0);
    test_field_extremes();
    test_bank_select();
    test_random_traffic(420, 13'h1FC0);
    set_bank(1'b1);
    test_random_traffic(420, 13'($urandom_range(0, 8191)));
    set_bank(1'b0);
    test_random_traffic(420, 13'($urandom_range(0, 8191)));
    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("palette_ram_color_converter_top_tb: clean");
    end else begin
      $display("palette_ram_color_converter_top_tb: errors");
    end
    $finish;
  end

endmodule
